// ----- rtl/bcm_pkg.sv -----
// shared types, codes and constants of the battery charge monitor
package bcm_pkg;

  localparam int unsigned WINDOW_DEF = 16;
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned ADC_MAX    = 4095;
  localparam int unsigned LVL_W      = 14;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned HUND_W     = 7;

  localparam logic [LVL_W-1:0] LOW_LEVEL_RST  = 14'd2000;
  localparam logic [LVL_W-1:0] FULL_LEVEL_RST = 14'd9500;
  localparam logic [MV_W-1:0]  FULL_SCALE_RST = 16'd12600;
  localparam logic [LVL_W-1:0] PCT_MAX        = 14'd10000;

  localparam logic CMD_PIN = 1'b0;
  localparam logic CMD_ADC = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    STAT_UNKNOWN     = 3'd0,
    STAT_CHARGING    = 3'd1,
    STAT_DISCHARGING = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_ABNORMAL    = 3'd4
  } status_e;

  typedef enum logic [CODE_W-1:0] {
    LED_OFF      = 3'd0,
    LED_COMPLETE = 3'd1,
    LED_CHARGING = 3'd2,
    LED_ABNORMAL = 3'd3,
    LED_LOW      = 3'd4
  } led_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_LOW_LEVEL  = 2'd0,
    CFG_FULL_LEVEL = 2'd1,
    CFG_FULL_SCALE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_WAIT,
    ST_DELIVER
  } fsm_e;

  typedef struct packed {
    logic             cmd;
    logic             pin_level;
    logic [ADC_W-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    led_e             led_mode;
    logic [ADC_W-1:0] average_sample;
    logic [MV_W-1:0]  voltage_mv;
    logic [LVL_W-1:0] percent;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [MV_W-1:0]  data;
  } cfg_item_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } win_ctrl_t;

  typedef struct packed {
    logic [ADC_W-1:0]  avg;
    logic [MV_W-1:0]   volt;
    logic [LVL_W-1:0]  pct;
    logic [HUND_W-1:0] hund_cnt;
  } calc_res_t;

  // bits for a running sum of a full window of samples
  function automatic int unsigned sum_width(input int unsigned win);
    return $clog2(win * ADC_MAX + 1);
  endfunction

endpackage

// ----- rtl/bcm_chan_if.sv -----
// valid/ready channel carrying one payload struct
interface bcm_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/battery_charge_monitor.sv -----
// battery charge monitor top level: control, pin status mailbox, registers and result stage
// a pin transaction gives no result; one can follow every cycle while the control is idle
// an adc transaction holds off further input until its result enters the output register;
// the result comes from the eleven-stage arithmetic pipeline in bcm_charge, used once per sample
// a finished result waits in the output register while the next transaction is accepted
// reset clears control state and the running sum; ring entries read as zero until first wrap
module battery_charge_monitor import bcm_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcm_chan_if.sink   in_i,
  bcm_chan_if.source out_o,
  bcm_chan_if.sink   cfg_i
);
  localparam int unsigned SUM_W = sum_width(WINDOW);

  fsm_e             state_q, state_d;
  logic [LVL_W-1:0] low_level_q, full_level_q;
  logic [MV_W-1:0]  full_scale_q;
  logic             last_pin_q, pin_known_q;
  logic             mb_full_q;
  status_e          mb_code_q;
  status_e          pin_code;
  logic             latch_q, latch_new;
  logic [ADC_W-1:0] sample_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic             in_ready;
  logic             in_acc;
  logic             adc_acc;
  logic             pin_acc;
  logic             cfg_acc;
  win_ctrl_t        win_ctrl;
  logic             calc_start;
  logic             calc_done;
  calc_res_t        calc_res;
  logic             out_load;
  logic [SUM_W-1:0] win_sum;
  status_e          stat_raw, stat_fin;
  led_e             led;
  logic [LVL_W-1:0] hund;

  bcm_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .sample_i (sample_q),
    .sum_o    (win_sum)
  );

  bcm_charge #(
    .WINDOW (WINDOW)
  ) u_charge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (calc_start),
    .sum_i        (win_sum),
    .full_scale_i (full_scale_q),
    .done_o       (calc_done),
    .res_o        (calc_res)
  );

  assign in_acc  = in_i.valid && in_ready;
  assign adc_acc = in_acc && (in_i.payload.cmd == CMD_ADC);
  assign pin_acc = in_acc && (in_i.payload.cmd == CMD_PIN);
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (adc_acc) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE:  state_d = ST_START;
      ST_START:   state_d = ST_WAIT;
      ST_WAIT: begin
        if (calc_done) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready    = (state_q == ST_IDLE);
    win_ctrl.rd = adc_acc;
    win_ctrl.wr = (state_q == ST_UPDATE);
    calc_start  = (state_q == ST_START);
    out_load    = (state_q == ST_DELIVER) && (!out_valid_q || out_o.ready);
  end

  always_comb begin
    if (in_i.payload.pin_level != last_pin_q) begin
      pin_code = STAT_ABNORMAL;
    end else if (in_i.payload.pin_level) begin
      pin_code = STAT_CHARGING;
    end else begin
      pin_code = STAT_DISCHARGING;
    end
  end

  // result assembly: mailbox status, full promotion, low-battery latch
  always_comb begin
    stat_raw  = mb_full_q ? mb_code_q : STAT_UNKNOWN;
    hund      = LVL_W'(calc_res.hund_cnt) * LVL_W'(100);
    stat_fin  = ((stat_raw == STAT_CHARGING) && (hund >= full_level_q)) ? STAT_FULL
                                                                         : stat_raw;
    latch_new = (stat_fin == STAT_CHARGING) ? 1'b0
                                            : (latch_q || (calc_res.pct < low_level_q));
    case (stat_fin)
      STAT_FULL:     led = LED_COMPLETE;
      STAT_CHARGING: led = LED_CHARGING;
      STAT_ABNORMAL: led = LED_ABNORMAL;
      default:       led = LED_OFF;
    endcase
    if (latch_new) begin
      led = LED_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      low_level_q  <= LOW_LEVEL_RST;
      full_level_q <= FULL_LEVEL_RST;
      full_scale_q <= FULL_SCALE_RST;
      last_pin_q   <= 1'b0;
      pin_known_q  <= 1'b0;
      mb_full_q    <= 1'b0;
      mb_code_q    <= STAT_UNKNOWN;
      latch_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        case (cfg_i.payload.index)
          CFG_LOW_LEVEL:  low_level_q  <= cfg_i.payload.data[LVL_W-1:0];
          CFG_FULL_LEVEL: full_level_q <= cfg_i.payload.data[LVL_W-1:0];
          CFG_FULL_SCALE: full_scale_q <= cfg_i.payload.data;
          default: ;
        endcase
      end
      if (pin_acc) begin
        // the first tick after reset only records the level
        if (pin_known_q && !mb_full_q) begin
          mb_full_q <= 1'b1;
          mb_code_q <= pin_code;
        end
        last_pin_q  <= in_i.payload.pin_level;
        pin_known_q <= 1'b1;
      end
      if (out_load) begin
        mb_full_q   <= 1'b0;
        latch_q     <= latch_new;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adc_acc) begin
      sample_q <= in_i.payload.adc_sample;
    end
    if (out_load) begin
      out_data_q.status         <= stat_fin;
      out_data_q.led_mode       <= led;
      out_data_q.average_sample <= calc_res.avg;
      out_data_q.voltage_mv     <= calc_res.volt;
      out_data_q.percent        <= calc_res.pct;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done |-> (state_q == ST_WAIT))
    else $error("calculation finished outside the wait state");

  a_adc_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adc_acc |=> (state_q == ST_UPDATE))
    else $error("adc transaction did not start a ring update");

  a_mailbox_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> !mb_full_q)
    else $error("mailbox still full after a result was loaded");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.percent <= PCT_MAX))
    else $error("percentage above full charge");

  a_low_led_follows_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((out_data_q.led_mode == LED_LOW) == latch_q))
    else $error("low battery led does not match the latch");
endmodule

// ----- rtl/bcm_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module bcm_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/bcm_window.sv -----
// sample ring in ram with write pointer, fill flag and running sum
module bcm_window import bcm_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  win_ctrl_t                      ctrl_i,
  input  logic [ADC_W-1:0]               sample_i,
  output logic [sum_width(WINDOW)-1:0]   sum_o
);
  localparam int unsigned SUM_W  = sum_width(WINDOW);
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              wrapped_q, wrapped_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [ADC_W-1:0]  rdata;
  logic [ADC_W-1:0]  old_sample;

  bcm_ram #(
    .WIDTH (ADC_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr),
    .waddr_i (slot_q),
    .wdata_i (sample_i),
    .re_i    (ctrl_i.rd),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  // entries not yet written since reset read as zero until the first wrap
  assign old_sample = wrapped_q ? rdata : '0;

  always_comb begin
    slot_d    = slot_q;
    wrapped_d = wrapped_q;
    sum_d     = sum_q;
    if (ctrl_i.wr) begin
      sum_d = (sum_q - SUM_W'(old_sample)) + SUM_W'(sample_i);
      if (slot_q == SLOT_LAST) begin
        slot_d    = '0;
        wrapped_d = 1'b1;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      wrapped_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      slot_q    <= slot_d;
      wrapped_q <= wrapped_d;
      sum_q     <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule

// ----- rtl/bcm_charge.sv -----
// fixed-point pipeline from window sum to average, voltage and charge percentage
module bcm_charge import bcm_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sum_width(WINDOW)-1:0] sum_i,
  input  logic [MV_W-1:0]              full_scale_i,
  output logic                         done_o,
  output calc_res_t                    res_o
);
  localparam int unsigned SUM_W  = sum_width(WINDOW);
  // t = ceil(sum * 625 / 256) stays below 4 * 2^SUM_W
  localparam int unsigned DIV_N  = SUM_W + 2;
  localparam int unsigned DIV_S  = DIV_N + $clog2(WINDOW);
  localparam int unsigned DIV_PW = DIV_N + DIV_S + 1;
  localparam logic [63:0] DIV_M_FULL =
    ((64'd1 << DIV_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [DIV_S:0] DIV_M = DIV_M_FULL[DIV_S:0];

  localparam int unsigned U_W   = 30;
  localparam int unsigned W_W   = 23;
  localparam int unsigned WSQ_W = 46;
  localparam int unsigned B_W   = 56;
  localparam int unsigned A_W   = 58;
  localparam int unsigned N_W   = 60;
  localparam int unsigned REM_W = 48;
  localparam int unsigned NSTG  = 11;

  localparam logic [30:0] M_W100  = 31'd1374389535;   // ceil(2^37 / 100)
  localparam logic [23:0] M_V100  = 24'd10737419;     // ceil(2^30 / 100)
  localparam logic [18:0] M_QE    = 19'd450359;       // floor(2^52 / 1e10)
  localparam logic [14:0] M_H100  = 15'd20972;        // ceil(2^21 / 100)
  localparam logic [32:0] B_COEF  = 33'd7068000000;
  localparam logic [11:0] A_COEF  = 12'd2746;
  localparam logic [N_W-1:0] C_COEF = 60'd4448780000000000;
  localparam logic [REM_W-1:0] E10  = 48'd10000000000;
  localparam logic [N_W-2:0] N_MAX  = 59'd100000000000000;

  logic [NSTG-1:0]      v_q;
  logic [DIV_N-1:0]     t_q, t_d;
  logic [DIV_N-1:0]     dw_op;
  logic [DIV_PW-1:0]    dw_prod;
  logic [ADC_W-1:0]     avg_q;
  logic [LVL_W-1:0]     frac_q;
  logic [U_W-1:0]       u_q;
  logic [W_W-1:0]       w_q;
  logic [WSQ_W-1:0]     wsq_q;
  logic [B_W-1:0]       b_q;
  logic [MV_W-1:0]      volt_q;
  logic [A_W-1:0]       a_q;
  logic signed [N_W-1:0] n_q, n_d;
  logic                 npos_q, nbig_q, npos_d;
  logic [LVL_W-1:0]     qe_q;
  logic [REM_W-1:0]     rem_q;
  logic [LVL_W-1:0]     pct_q, pct_d;
  logic [HUND_W-1:0]    hc_q;
  logic [SUM_W+9:0]     t_mul;
  logic [60:0]          w_prod;
  logic [46:0]          v_prod;
  logic [45:0]          qe_prod;
  logic [28:0]          hc_prod;

  // sum * 10000 / 4096 = sum * 625 / 256, ceiling kept through the nested divide
  assign t_mul = ((SUM_W+10)'(sum_i) * (SUM_W+10)'(625)) + (SUM_W+10)'(255);
  assign t_d   = t_mul[SUM_W+9:8];

  // one reciprocal multiplier divides by the window: first the sum, then t
  assign dw_op   = start_i ? DIV_N'(sum_i) : (t_q + DIV_N'(WINDOW - 1));
  assign dw_prod = DIV_PW'(dw_op) * DIV_PW'(DIV_M);

  assign w_prod  = 61'(u_q) * 61'(M_W100);
  assign v_prod  = 47'(w_q) * 47'(M_V100);
  assign n_d     = $signed(N_W'(b_q)) - $signed(N_W'(a_q)) - $signed(C_COEF);
  assign npos_d  = !n_q[N_W-1] && (n_q != '0);
  assign qe_prod = 46'(n_q[46:20]) * 46'(M_QE);
  assign hc_prod = (29'(pct_q) + 29'(99)) * 29'(M_H100);

  // quotient estimate is exact or one low, the remainder settles the ceiling
  always_comb begin
    if (!npos_q) begin
      pct_d = '0;
    end else if (nbig_q) begin
      pct_d = PCT_MAX;
    end else begin
      pct_d = qe_q + LVL_W'(rem_q != '0) + LVL_W'(rem_q > E10);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NSTG-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q   <= t_d;
      avg_q <= dw_prod[DIV_S +: ADC_W];
    end
    if (v_q[0]) begin
      frac_q <= dw_prod[DIV_S +: LVL_W];
    end
    if (v_q[1]) begin
      u_q <= U_W'(frac_q) * U_W'(full_scale_i);
    end
    if (v_q[2]) begin
      w_q <= w_prod[37 +: W_W];
    end
    if (v_q[3]) begin
      wsq_q  <= WSQ_W'(w_q) * WSQ_W'(w_q);
      b_q    <= B_W'(w_q) * B_W'(B_COEF);
      volt_q <= v_prod[30 +: MV_W];
    end
    if (v_q[4]) begin
      a_q <= A_W'(wsq_q) * A_W'(A_COEF);
    end
    if (v_q[5]) begin
      n_q <= n_d;
    end
    if (v_q[6]) begin
      npos_q <= npos_d;
      nbig_q <= npos_d && (n_q[N_W-2:0] > N_MAX);
      qe_q   <= qe_prod[32 +: LVL_W];
    end
    if (v_q[7]) begin
      rem_q <= n_q[REM_W-1:0] - (REM_W'(qe_q) * E10);
    end
    if (v_q[8]) begin
      pct_q <= pct_d;
    end
    if (v_q[9]) begin
      hc_q <= hc_prod[21 +: HUND_W];
    end
  end

  assign done_o         = v_q[NSTG-1];
  assign res_o.avg      = avg_q;
  assign res_o.volt     = volt_q;
  assign res_o.pct      = pct_q;
  assign res_o.hund_cnt = hc_q;
endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench of the battery charge monitor with its own charge predictor
`timescale 1ns / 100ps

module tb_top;
  import bcm_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 9;
  localparam int SETTLE_CYC  = 24;       // a bit more than one adc transaction takes
  localparam int HOLD_CYCLES = 300;
  localparam int END_WAIT    = 5000;
  localparam int PHASE_ITEMS = 205;
  localparam int NDIR        = 20;
  localparam int MAX_PRINTS  = 40;
  localparam longint TIMEOUT_NS = 4_000_000;

  // index that maps to no register, writes to it must be dropped
  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic             cmd;
    logic             pin;
    logic [ADC_W-1:0] adc;
    bit               typed;
    out_item_t        want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  bcm_chan_if #(.payload_t(in_item_t))  in_ch ();
  bcm_chan_if #(.payload_t(out_item_t)) out_ch ();
  bcm_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

  battery_charge_monitor dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // predictor state
  logic [ADC_W-1:0] ring [WINDOW_DEF];
  int unsigned      sum_acc;
  int unsigned      slot;
  logic             last_pin;
  bit               pin_known;
  bit               mbox_full;
  status_e          mbox_code;
  bit               low_latch;
  logic [LVL_W-1:0] low_reg;
  logic [LVL_W-1:0] full_reg;
  logic [MV_W-1:0]  fsm_reg;

  out_item_t charge_q[$];

  int n_errors;
  int n_items;
  int n_checked;
  int n_settings;
  int status_seen [5];
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;

  out_item_t got_r;
  out_item_t want_r;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic void reset_monitor();
    for (int i = 0; i < WINDOW_DEF; i++) ring[i] = '0;
    sum_acc   = 0;
    slot      = 0;
    last_pin  = 1'b0;
    pin_known = 1'b0;
    mbox_full = 1'b0;
    mbox_code = STAT_UNKNOWN;
    low_latch = 1'b0;
    low_reg   = LOW_LEVEL_RST;
    full_reg  = FULL_LEVEL_RST;
    fsm_reg   = FULL_SCALE_RST;
  endfunction

  // advances the monitor by one transaction, returns 1 when an adc tick gives a result
  function automatic bit step_monitor(input in_item_t it, output out_item_t res);
    longint  den;
    longint  frac;
    longint  u;
    longint  w;
    longint  n;
    longint  pct;
    longint  hund;
    status_e st;
    led_e    led;
    res = '0;
    if (it.cmd == CMD_PIN) begin
      if (pin_known && !mbox_full) begin
        mbox_full = 1'b1;
        if (it.pin_level != last_pin) mbox_code = STAT_ABNORMAL;
        else if (it.pin_level) mbox_code = STAT_CHARGING;
        else mbox_code = STAT_DISCHARGING;
      end
      last_pin  = it.pin_level;
      pin_known = 1'b1;
      return 1'b0;
    end

    sum_acc    = sum_acc - ring[slot] + it.adc_sample;
    ring[slot] = it.adc_sample;
    slot       = (slot + 1) % WINDOW_DEF;

    den  = longint'(WINDOW_DEF) * 4096;
    frac = (longint'(sum_acc) * 10000 + den - 1) / den;
    u    = frac * longint'(fsm_reg);
    w    = u / 100;
    n    = -2746 * w * w + 64'sd7068000000 * w - 64'sd4448780000000000;
    if (n <= 0) begin
      pct = 0;
    end else begin
      pct = (n + 64'sd9999999999) / 64'sd10000000000;
      if (pct > longint'(PCT_MAX)) pct = longint'(PCT_MAX);
    end

    if (mbox_full) begin
      st        = mbox_code;
      mbox_full = 1'b0;
    end else begin
      st = STAT_UNKNOWN;
    end
    hund = ((pct + 99) / 100) * 100;
    if (st == STAT_CHARGING && hund >= longint'(full_reg)) st = STAT_FULL;

    if (pct < longint'(low_reg)) low_latch = 1'b1;
    led = LED_OFF;
    case (st)
      STAT_FULL: begin
        led = LED_COMPLETE;
      end
      STAT_CHARGING: begin
        led       = LED_CHARGING;
        low_latch = 1'b0;
      end
      STAT_ABNORMAL: begin
        led = LED_ABNORMAL;
      end
      default: ;
    endcase
    if (low_latch) led = LED_LOW;

    status_seen[st]++;
    res.status         = st;
    res.led_mode       = led;
    res.average_sample = ADC_W'(sum_acc / WINDOW_DEF);
    res.voltage_mv     = MV_W'(u / 10000);
    res.percent        = LVL_W'(pct);
    return 1'b1;
  endfunction

  function automatic out_item_t flat_result(input status_e s, input led_e l);
    out_item_t r;
    r          = '0;
    r.status   = s;
    r.led_mode = l;
    return r;
  endfunction

  // offers one transaction, with a random gap in front, and predicts it once accepted
  task automatic send_item(input in_item_t it);
    out_item_t res;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
    if (step_monitor(it, res)) charge_q.push_back(res);
  endtask

  // valid is left high, the caller lowers it after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.payload.index <= idx;
    cfg_ch.payload.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_LOW_LEVEL:  low_reg  = data[LVL_W-1:0];
      CFG_FULL_LEVEL: full_reg = data[LVL_W-1:0];
      CFG_FULL_SCALE: fsm_reg  = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [MV_W-1:0] low, input logic [MV_W-1:0] full,
                          input logic [MV_W-1:0] fsm, input bit poke_unused);
    while (charge_q.size() != 0) @(posedge clk);
    // a trailing pin transaction may still be in flight
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(CFG_LOW_LEVEL, low);
    write_reg(CFG_FULL_LEVEL, full);
    write_reg(CFG_FULL_SCALE, fsm);
    if (poke_unused) write_reg(CFG_UNUSED, MV_W'($urandom_range(0, 65535)));
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // episodes of one charger behaviour around one battery level, plus some noise
  task automatic run_random(input int count);
    in_item_t it;
    int       done;
    int       mode;
    int       level;
    int       len;
    int       smp;
    logic     pin_now;
    done    = 0;
    pin_now = 1'b0;
    while (done < count) begin
      mode = $urandom_range(0, 9);
      if (fsm_reg != 0 && $urandom_range(0, 9) < 8)
        level = $urandom_range(10500, 13200) * 4096 / int'(fsm_reg);
      else
        level = $urandom_range(0, 4095);
      if (level > 4095) level = 4095;
      len = $urandom_range(4, 24);
      for (int k = 0; k < len && done < count; k++) begin
        it.cmd = ($urandom_range(0, 2) == 0) ? CMD_PIN : CMD_ADC;
        if (mode <= 3) pin_now = 1'b1;
        else if (mode <= 6) pin_now = 1'b0;
        else if (mode == 7) pin_now = ~pin_now;
        else pin_now = 1'($urandom_range(0, 1));
        // an odd glitch on an otherwise steady pin
        if (mode <= 6 && $urandom_range(0, 19) == 0) pin_now = ~pin_now;
        if ($urandom_range(0, 9) == 0) begin
          smp = $urandom_range(0, 4095);
        end else begin
          smp = level + $urandom_range(0, 128) - 64;
          if (smp < 0) smp = 0;
          if (smp > 4095) smp = 4095;
        end
        it.pin_level  = pin_now;
        it.adc_sample = ADC_W'(smp);
        send_item(it);
        done++;
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver: random stalls, and a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int holds_done;
    hold_left    = 0;
    holds_done   = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (holds_done != hold_reqs) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_r = out_ch.payload;
      if (charge_q.size() == 0) begin
        report_mismatch("result with nothing pending", got_r.percent, 0);
      end else begin
        want_r = charge_q.pop_front();
        n_checked++;
        if (got_r.status !== want_r.status)
          report_mismatch("status", got_r.status, want_r.status);
        if (got_r.led_mode !== want_r.led_mode)
          report_mismatch("led_mode", got_r.led_mode, want_r.led_mode);
        if (got_r.average_sample !== want_r.average_sample)
          report_mismatch("average_sample", got_r.average_sample, want_r.average_sample);
        if (got_r.voltage_mv !== want_r.voltage_mv)
          report_mismatch("voltage_mv", got_r.voltage_mv, want_r.voltage_mv);
        if (got_r.percent !== want_r.percent)
          report_mismatch("percent", got_r.percent, want_r.percent);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timed out with %0d results outstanding", charge_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [NDIR];
    in_item_t it;
    int       waited;

    n_errors    = 0;
    n_items     = 0;
    n_checked   = 0;
    n_settings  = 1;
    hold_reqs   = 0;
    tx_idle_pct = 9;
    rx_idle_pct = 9;
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    reset_monitor();

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;

    // pin ticks walk through the mailbox; zero samples keep checked numbers at zero
    dir_rows = '{
      '{CMD_ADC, 1'b0, 12'd0,    1'b1, flat_result(STAT_UNKNOWN, LED_LOW)},
      '{CMD_PIN, 1'b1, 12'd4095, 1'b0, '0},
      '{CMD_PIN, 1'b1, 12'd0,    1'b0, '0},
      '{CMD_PIN, 1'b0, 12'd0,    1'b0, '0},
      '{CMD_ADC, 1'b1, 12'd0,    1'b1, flat_result(STAT_CHARGING, LED_CHARGING)},
      '{CMD_PIN, 1'b0, 12'd4095, 1'b0, '0},
      '{CMD_ADC, 1'b0, 12'd0,    1'b1, flat_result(STAT_DISCHARGING, LED_LOW)},
      '{CMD_PIN, 1'b1, 12'd0,    1'b0, '0},
      '{CMD_ADC, 1'b1, 12'd0,    1'b1, flat_result(STAT_ABNORMAL, LED_LOW)},
      '{CMD_ADC, 1'b0, 12'd0,    1'b1, flat_result(STAT_UNKNOWN, LED_LOW)},
      '{CMD_ADC, 1'b1, 12'd4095, 1'b0, '0},
      '{CMD_ADC, 1'b0, 12'd4095, 1'b0, '0},
      '{CMD_ADC, 1'b1, 12'd2730, 1'b0, '0},
      '{CMD_ADC, 1'b0, 12'd1365, 1'b0, '0},
      '{CMD_PIN, 1'b1, 12'd0,    1'b0, '0},
      '{CMD_PIN, 1'b1, 12'd0,    1'b0, '0},
      '{CMD_ADC, 1'b0, 12'd4095, 1'b0, '0},
      '{CMD_ADC, 1'b1, 12'd4094, 1'b0, '0},
      '{CMD_ADC, 1'b0, 12'd1,    1'b0, '0},
      '{CMD_ADC, 1'b1, 12'd4095, 1'b0, '0}
    };

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[r]) begin
      it.cmd        = dir_rows[r].cmd;
      it.pin_level  = dir_rows[r].pin;
      it.adc_sample = dir_rows[r].adc;
      send_item(it);
      if (dir_rows[r].typed && it.cmd == CMD_ADC) charge_q[$] = dir_rows[r].want;
    end
    run_random(PHASE_ITEMS);

    // extremes, with no idling on either side
    set_regs(16'd0, 16'd0, 16'd65535, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PHASE_ITEMS);
    tx_idle_pct = 9;
    rx_idle_pct = 9;

    set_regs(16'd10000, 16'd10000, 16'd0, 1'b0);
    run_random(PHASE_ITEMS);

    // out of range levels are masked, the spare index is ignored
    set_regs(16'hFFFF, 16'hFFFF, 16'd13000, 1'b1);
    hold_reqs++;
    run_random(PHASE_ITEMS);

    for (int p = 0; p < 3; p++) begin
      set_regs(MV_W'($urandom_range(0, 10000)), MV_W'($urandom_range(0, 10000)),
               MV_W'($urandom_range(11000, 15000)), 1'b0);
      if (p == 1) hold_reqs++;
      run_random(PHASE_ITEMS);
    end

    set_regs(MV_W'(LOW_LEVEL_RST), MV_W'(FULL_LEVEL_RST), FULL_SCALE_RST, 1'b0);
    run_random(PHASE_ITEMS);

    waited = 0;
    while (charge_q.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (charge_q.size() != 0) report_mismatch("results never delivered", charge_q.size(), 0);

    $display("%0d input transactions, %0d results checked under %0d register settings",
             n_items, n_checked, n_settings);
    $display("status unknown/charging/discharging/full/abnormal predicted %0d/%0d/%0d/%0d/%0d",
             status_seen[STAT_UNKNOWN], status_seen[STAT_CHARGING],
             status_seen[STAT_DISCHARGING], status_seen[STAT_FULL], status_seen[STAT_ABNORMAL]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
